[design/monotone_grid_path_reachability_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef MONOTONE_GRID_PATH_REACHABILITY_MACROS_SVH
`define MONOTONE_GRID_PATH_REACHABILITY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define MGPR_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MGPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MGPR_ASSERT(lbl, ante, cons, msg)
`define MGPR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/mgpr_pkg.sv]
package mgpr_pkg;

	// Grid store size
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// Configuration register width and indexes
	localparam int SIZE_W = 5;
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Controls broadcast from the sequencer to every column cell
	typedef struct packed {
		logic             wr;
		logic [ROW_W-1:0] wr_row;
		logic             wr_safe;
		logic [ROW_W-1:0] rd_row;
		logic             sweep;
		logic             first;
	} mgpr_ctl_t;

endpackage

[design/mgpr_cell.sv]
// One grid column: its safe bits for every row and its reach bit of the
// row last swept. The reach decision ripples from the right neighbor.
module mgpr_cell
	import mgpr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mgpr_ctl_t ctl,
	input  logic      col_sel,
	input  logic      col_used,
	input  logic      right_in,
	output logic      here,
	output logic      reach
);

	logic [MAX_ROWS-1:0] safe_col_q;
	logic                reach_q;
	logic                safe_bit;

	// Safe bit of the row being swept, masked to the used width
	assign safe_bit = safe_col_q[ctl.rd_row] & col_used;

	// Row 0 takes the safe bits as is; later rows need up or right reach
	assign here  = safe_bit & (ctl.first | reach_q | right_in);
	assign reach = reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_col_q <= '0;
			reach_q    <= 1'b0;
		end else begin
			if (ctl.wr && col_sel) begin
				safe_col_q[ctl.wr_row] <= ctl.wr_safe;
			end
			if (ctl.sweep) begin
				reach_q <= here;
			end
		end
	end

endmodule

[design/monotone_grid_path_reachability.sv]
// Up/right path reachability over a grid of safe and mined cells.
// Input channel (in_valid/in_ready): req_type 0 writes one cell (row, col,
// cell_safe); req_type 1 queries whether a path of up and right moves leads
// from the start cell (row, col) to row 0 without entering a mine.
// Output channel (out_valid/out_ready): one transaction per query with
// path_exists and start_out_of_bounds; writes give no result.
// Config port (cfg_we/cfg_index/cfg_wdata): rows and columns in use; write
// only while idle.
// A write is stored when it is accepted. A query with start row r sweeps one
// grid row per cycle through the column cell chain, rows 0 to r, then posts
// the result from the finish state. An out-of-bounds start skips the sweep.
// The block returns to idle as the result posts and then takes the next item.
// One item is in work at a time; writes are taken while a result waits.
// Reset clears the whole grid to mined and the sizes to 16 by 16.
// A stalled receiver holds the result; a finished query waits for the
// result slot before the next item is taken.
`include "monotone_grid_path_reachability_macros.svh"

module monotone_grid_path_reachability
	import mgpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic signed [5:0] row,
	input  logic signed [5:0] col,
	input  logic              cell_safe,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              path_exists,
	output logic              start_out_of_bounds,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] rows_q, cols_q;
	logic [SIZE_W-1:0] nrows, ncols;
	logic [ROW_W-1:0]  cnt_q, r_q;
	logic [COL_W-1:0]  c_q;
	logic              oob_q;
	logic              out_valid_q, path_q, out_oob_q;

	logic              in_acc;
	logic              in_store, in_grid;
	logic              slot_free;
	mgpr_ctl_t         ctl;
	logic [MAX_COLS:0] here;
	logic [MAX_COLS-1:0] reach;

	// Used sizes: zero acts as one, above the store acts as the store size
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input int maxv);
		logic [SIZE_W-1:0] res;
		if (v == '0) begin
			res = SIZE_W'(1);
		end else if ({2'b00, v} > 7'(maxv)) begin
			res = SIZE_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	assign nrows = clamp_size(rows_q, MAX_ROWS);
	assign ncols = clamp_size(cols_q, MAX_COLS);

	// Range checks on the request coordinates
	assign in_store = !row[5] && !col[5] &&
		({1'b0, row} < 7'(MAX_ROWS)) && ({1'b0, col} < 7'(MAX_COLS));
	assign in_grid  = !row[5] && !col[5] &&
		({1'b0, row} < {2'b00, nrows}) && ({1'b0, col} < {2'b00, ncols});

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Cell chain controls
	always_comb begin
		ctl.wr      = in_acc && (req_type == REQ_WRITE) && in_store;
		ctl.wr_row  = row[ROW_W-1:0];
		ctl.wr_safe = cell_safe;
		ctl.rd_row  = cnt_q;
		ctl.sweep   = (state_q == ST_SWEEP);
		ctl.first   = (cnt_q == '0);
	end

	assign here[MAX_COLS] = 1'b0;

	// One cell per column; reach ripples right to left
	for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
		mgpr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.col_sel  (col[COL_W-1:0] == COL_W'(j)),
			.col_used (7'(j) < {2'b00, ncols}),
			.right_in (here[j+1]),
			.here     (here[j]),
			.reach    (reach[j])
		);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_W'(16);
			cols_q <= SIZE_W'(16);
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS) begin
				rows_q <= cfg_wdata;
			end
			if (cfg_index == CFG_COLS) begin
				cols_q <= cfg_wdata;
			end
		end
	end

	// Query sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			oob_q       <= 1'b0;
			out_valid_q <= 1'b0;
			path_q      <= 1'b0;
			out_oob_q   <= 1'b0;
		end else begin
			// Result valid: set when a result posts, cleared once taken
			if ((state_q == ST_FINISH) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == REQ_QUERY)) begin
						r_q   <= row[ROW_W-1:0];
						c_q   <= col[COL_W-1:0];
						oob_q <= !in_grid;
						cnt_q <= '0;
						state_q <= in_grid ? ST_SWEEP : ST_FINISH;
					end
				end
				ST_SWEEP: begin
					if (cnt_q == r_q) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + ROW_W'(1);
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						path_q      <= !oob_q && reach[c_q];
						out_oob_q   <= oob_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid           = out_valid_q;
	assign path_exists         = path_q;
	assign start_out_of_bounds = out_oob_q;

	// Checks
	`MGPR_ASSERT(a_oob_no_path, out_valid && start_out_of_bounds, !path_exists, "path on oob start")
	`MGPR_ASSERT(a_cnt_bound, state_q == ST_SWEEP, cnt_q <= r_q, "sweep passed start row")
	`MGPR_ASSERT_NEXT(a_query_sweeps, in_acc && req_type == REQ_QUERY && in_grid, state_q == ST_SWEEP, "query did not start sweep")
	`MGPR_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(path_exists), "result dropped while stalled")

endmodule

[tb/tb_monotone_grid_path_reachability.sv]
`timescale 1ns / 1ps

module tb_monotone_grid_path_reachability;
	import mgpr_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 200;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic path_exists;
		logic start_oob;
	} reach_answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              req_type = REQ_WRITE;
	logic signed [5:0] row = '0;
	logic signed [5:0] col = '0;
	logic              cell_safe = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              path_exists;
	logic              start_out_of_bounds;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_ROWS;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	// Mirror of the grid and the size registers
	logic [MAX_COLS-1:0] grid_model [MAX_ROWS];
	logic [SIZE_W-1:0]   rows_reg;
	logic [SIZE_W-1:0]   cols_reg;
	reach_answer_t       pending_answers [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int writes_sent;
	int queries_sent;
	int paths_found;
	int oob_starts;
	int settings_run;
	int stall_cycles;

	monotone_grid_path_reachability u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.req_type            (req_type),
		.row                 (row),
		.col                 (col),
		.cell_safe           (cell_safe),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.path_exists         (path_exists),
		.start_out_of_bounds (start_out_of_bounds),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Size register as the block uses it: zero acts as one, large values clamp
	function automatic int used_size(input logic [SIZE_W-1:0] value, input int max_size);
		if (value == 0)
			return 1;
		if (int'(value) > max_size)
			return max_size;
		return int'(value);
	endfunction

	// Row-0 reachability sweep from row 0 down to the start row
	function automatic reach_answer_t reach_from(input int r, input int c);
		reach_answer_t       ans;
		int                  nr;
		int                  nc;
		logic [MAX_COLS-1:0] used;
		logic [MAX_COLS-1:0] reach;
		logic [MAX_COLS-1:0] next_reach;
		logic [MAX_COLS-1:0] safe_bits;
		logic                right;
		nr = used_size(rows_reg, MAX_ROWS);
		nc = used_size(cols_reg, MAX_COLS);
		ans = '0;
		if (r < 0 || r >= nr || c < 0 || c >= nc) begin
			ans.start_oob = 1'b1;
			return ans;
		end
		used = '0;
		for (int j = 0; j < nc; j++)
			used[j] = 1'b1;
		reach = grid_model[0] & used;
		for (int i = 1; i <= r; i++) begin
			safe_bits = grid_model[i] & used;
			next_reach = '0;
			right = 1'b0;
			for (int j = nc - 1; j >= 0; j--) begin
				next_reach[j] = safe_bits[j] && (reach[j] || right);
				right = next_reach[j];
			end
			reach = next_reach;
		end
		ans.path_exists = reach[c];
		return ans;
	endfunction

	// One input transaction; the model is updated at acceptance
	task automatic send_item(input logic kind, input int r, input int c, input logic safe);
		reach_answer_t ans;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= kind;
		row       <= r[5:0];
		col       <= c[5:0];
		cell_safe <= safe;
		do @(posedge clk); while (!in_ready);
		if (kind == REQ_WRITE) begin
			writes_sent++;
			if (r >= 0 && r < MAX_ROWS && c >= 0 && c < MAX_COLS)
				grid_model[r][c] = safe;
		end else begin
			queries_sent++;
			ans = reach_from(r, c);
			if (ans.path_exists)
				paths_found++;
			if (ans.start_oob)
				oob_starts++;
			pending_answers.push_back(ans);
		end
	endtask

	// Stop sending and let the block go idle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic idx, input logic [SIZE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_ROWS)
			rows_reg = value;
		else
			cols_reg = value;
	endtask

	// Result check and receiver stalls
	always @(posedge clk) begin : check_answers
		reach_answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("result with no query pending: path_exists=%0b oob=%0b",
						path_exists, start_out_of_bounds);
			end else begin
				want = pending_answers.pop_front();
				if (path_exists !== want.path_exists ||
						start_out_of_bounds !== want.start_oob) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: expected path_exists=%0b oob=%0b, got %0b %0b",
							want.path_exists, want.start_oob, path_exists,
							start_out_of_bounds);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb_monotone_grid_path_reachability NOT OK");
			$finish;
		end
	end

	// Grid is all mined after reset; starts inside give no path, starts outside are out of bounds
	task automatic test_empty_grid();
		send_item(REQ_QUERY, 0, 0, 1'b1);
		send_item(REQ_QUERY, 15, 15, 1'b0);
		send_item(REQ_QUERY, 7, 3, 1'b1);
		send_item(REQ_QUERY, -1, 0, 1'b0);
		send_item(REQ_QUERY, 0, -32, 1'b1);
		send_item(REQ_QUERY, 31, 31, 1'b0);
		send_item(REQ_QUERY, 16, 0, 1'b0);
		send_item(REQ_QUERY, 0, 16, 1'b1);
	endtask

	// Writes outside the store are dropped
	task automatic test_store_bounds();
		send_item(REQ_WRITE, -1, 3, 1'b1);
		send_item(REQ_WRITE, 31, -32, 1'b1);
		send_item(REQ_WRITE, 16, 0, 1'b1);
		send_item(REQ_WRITE, -32, 31, 1'b1);
		send_item(REQ_QUERY, 15, 0, 1'b0);
	endtask

	// Right-then-up path, start on a mine, and a path cut by a new mine
	task automatic test_path_shapes();
		send_item(REQ_WRITE, 0, 15, 1'b1);
		send_item(REQ_WRITE, 1, 15, 1'b1);
		send_item(REQ_WRITE, 2, 15, 1'b1);
		send_item(REQ_WRITE, 3, 15, 1'b1);
		send_item(REQ_WRITE, 3, 14, 1'b1);
		send_item(REQ_QUERY, 3, 14, 1'b0);
		send_item(REQ_QUERY, 3, 15, 1'b1);
		send_item(REQ_QUERY, 2, 14, 1'b0);
		send_item(REQ_WRITE, 1, 15, 1'b0);
		send_item(REQ_QUERY, 3, 14, 1'b1);
		send_item(REQ_WRITE, 0, 0, 1'b1);
		send_item(REQ_QUERY, 0, 0, 1'b0);
	endtask

	// Random traffic: whole-row loads, single writes and queries
	task automatic run_random(input int count);
		int nr;
		int nc;
		int sent;
		int pick;
		int r;
		int c;
		nr = used_size(rows_reg, MAX_ROWS);
		nc = used_size(cols_reg, MAX_COLS);
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				r = $urandom_range(nr - 1);
				for (int j = 0; j < nc; j++)
					send_item(REQ_WRITE, r, j, $urandom_range(99) < 80);
				sent += nc;
			end else if (pick < 45) begin
				if ($urandom_range(9) == 0) begin
					r = int'($urandom_range(63)) - 32;
					c = int'($urandom_range(63)) - 32;
				end else if ($urandom_range(3) == 0) begin
					r = $urandom_range(MAX_ROWS - 1);
					c = $urandom_range(MAX_COLS - 1);
				end else begin
					r = $urandom_range(nr - 1);
					c = $urandom_range(nc - 1);
				end
				send_item(REQ_WRITE, r, c, $urandom_range(99) < 75);
				sent++;
			end else begin
				if ($urandom_range(6) == 0) begin
					r = int'($urandom_range(63)) - 32;
					c = int'($urandom_range(63)) - 32;
				end else begin
					r = $urandom_range(nr - 1);
					c = $urandom_range(nc - 1);
				end
				send_item(REQ_QUERY, r, c, $urandom_range(1));
				sent++;
			end
		end
	endtask

	// Size settings from the extremes to random values, idling pattern per third
	task automatic test_size_settings();
		int rows_list [9];
		int cols_list [9];
		rows_list = '{16, 0, 1, 16, 31, 5, 4, 0, 0};
		cols_list = '{16, 0, 16, 1, 31, 9, 4, 0, 0};
		rows_list[7] = $urandom_range(31);
		cols_list[7] = $urandom_range(31);
		rows_list[8] = $urandom_range(1, 16);
		cols_list[8] = $urandom_range(1, 16);
		for (int p = 0; p < 9; p++) begin
			drain_block();
			write_size(CFG_ROWS, rows_list[p][SIZE_W-1:0]);
			write_size(CFG_COLS, cols_list[p][SIZE_W-1:0]);
			if (p < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 75;
			end else if (p < 6) begin
				send_idle_pct = 75;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settings_run++;
			run_random(PHASE_ITEMS);
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_ROWS; i++)
			grid_model[i] = '0;
		rows_reg = 5'd16;
		cols_reg = 5'd16;
		send_idle_pct = 25;
		recv_idle_pct = 75;
		fail_count = 0;
		writes_sent = 0;
		queries_sent = 0;
		paths_found = 0;
		oob_starts = 0;
		settings_run = 0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_grid();
		test_store_bounds();
		test_path_shapes();
		test_size_settings();

		drain_block();
		if (pending_answers.size() != 0)
			fail_count += pending_answers.size();
		$display("Sent %0d cell writes and %0d queries over %0d grid size settings.",
			writes_sent, queries_sent, settings_run);
		$display("Queries found %0d paths and %0d out-of-bounds starts.",
			paths_found, oob_starts);
		if (fail_count == 0)
			$display("tb_monotone_grid_path_reachability OK");
		else
			$display("tb_monotone_grid_path_reachability NOT OK");
		$finish;
	end

endmodule
